// ===== sv/trie_shortest_unique_prefix_defines.svh =====
// ----------------------------------------------------------------------------
// Trie shortest unique prefix: assertion macros
// Shared concurrent assertion forms for the block's RTL files.
// ----------------------------------------------------------------------------
`ifndef TRIE_SHORTEST_UNIQUE_PREFIX_DEFINES_SVH
`define TRIE_SHORTEST_UNIQUE_PREFIX_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TSUP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TSUP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsup_pkg.sv =====
// ----------------------------------------------------------------------------
// Trie shortest unique prefix: package
// Field widths, default sizes, codes and state type shared by the block.
// ----------------------------------------------------------------------------
package tsup_pkg;

    // Fixed field widths
    localparam int LETTER_W = 5;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Default sizes
    localparam int NODE_COUNT_DEF    = 4096;
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_WORD_LEN_DEF  = 64;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_LONG = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ===== sv/tsup_if.sv =====
// ----------------------------------------------------------------------------
// Trie shortest unique prefix: channel interfaces
// Letter request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsup_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [tsup_pkg::LETTER_W-1:0] letter;
    logic                          last;

    modport source (output valid, output req_type, output letter, output last, input ready);
    modport sink   (input valid, input req_type, input letter, input last, output ready);
endinterface

interface tsup_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsup_pkg::LEN_W-1:0]    prefix_len;
    logic [tsup_pkg::STATUS_W-1:0] status;

    modport source (output valid, output prefix_len, output status, input ready);
    modport sink   (input valid, input prefix_len, input status, output ready);
endinterface

// ===== sv/trie_shortest_unique_prefix.sv =====
// A word's result is registered when its last letter executes; the last letter
// holds for as long as an earlier result waits in the result register.
// A new letter is taken only once the previous one has done the read-modify-write
// of the child row memory (read when the letter transfers, update as it executes).
// Reset: synchronous, active low; afterwards a clearing pass zeroes all NODE_COUNT
// rows of the child memory one row a cycle, with no letter accepted.
// ----------------------------------------------------------------------------
// Trie shortest unique prefix
// Array trie fed one letter per transfer; each word-final letter yields the
// shortest unique prefix length (queries) and a status code.
// ----------------------------------------------------------------------------
`include "trie_shortest_unique_prefix_defines.svh"

module trie_shortest_unique_prefix #(
    parameter int NODE_COUNT    = tsup_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = tsup_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_WORD_LEN  = tsup_pkg::MAX_WORD_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsup_req_if.sink   i_req,
    tsup_rsp_if.source o_rsp
);

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int SYM_W    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int POS_W    = $clog2(MAX_WORD_LEN + 1);
    localparam int CNT_W    = tsup_pkg::CNT_W;
    localparam int LANE_W   = CNT_W + NODE_W;
    localparam int N_LETTER = 2 ** tsup_pkg::LETTER_W;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
    localparam logic [FREE_W-1:0] FREE_LIM  = FREE_W'(NODE_COUNT);
    localparam logic [POS_W-1:0]  POS_LIM   = POS_W'(MAX_WORD_LEN);

    // Each row holds, per letter, the child's pass count and node index
    logic [ALPHABET_SIZE-1:0][LANE_W-1:0] mem_child [NODE_COUNT];

    logic [SYM_W-1:0] w_sym_tab [N_LETTER];

    tsup_pkg::t_state  r_state, n_state;
    logic [NODE_W-1:0] r_clr;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]  r_cur_cnt, n_cur_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_found, n_found;
    logic [POS_W-1:0]  r_found_len, n_found_len;
    tsup_pkg::t_status r_err, n_err;
    logic [FREE_W-1:0] r_next_free, n_next_free;

    tsup_pkg::t_req    r_req;
    logic [SYM_W-1:0]  r_sym;
    logic              r_last;
    logic [ALPHABET_SIZE-1:0][LANE_W-1:0] r_row;

    logic                       r_out_valid;
    logic [tsup_pkg::LEN_W-1:0] r_out_len, n_out_len;
    tsup_pkg::t_status          r_out_status;

    logic              w_accept;
    logic              w_fire;
    logic              w_clr_we;
    logic              w_out_free;
    logic              w_we;
    logic              w_alloc;
    logic [LANE_W-1:0] w_wlane;
    logic [LANE_W-1:0] w_lane;
    logic [NODE_W-1:0] w_lane_ptr;
    logic [CNT_W-1:0]  w_lane_cnt;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [POS_W-1:0]  w_len;

    // Letter code folded into the alphabet, worked out at elaboration
    for (genvar k = 0; k < N_LETTER; k++) begin : g_sym
        assign w_sym_tab[k] = SYM_W'(k % ALPHABET_SIZE);
    end

    // ---------------- control ----------------
    always_comb begin
        unique case (r_state)
            tsup_pkg::S_CLEAR: n_state = (r_clr == LAST_NODE) ? tsup_pkg::S_IDLE
                                                                : tsup_pkg::S_CLEAR;
            tsup_pkg::S_IDLE:  n_state = w_accept ? tsup_pkg::S_EXEC : tsup_pkg::S_IDLE;
            tsup_pkg::S_EXEC:  n_state = w_fire ? tsup_pkg::S_IDLE : tsup_pkg::S_EXEC;
            default:           n_state = tsup_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        w_out_free  = !r_out_valid || o_rsp.ready;
        i_req.ready = (r_state == tsup_pkg::S_IDLE);
        w_accept    = i_req.valid && i_req.ready;
        w_clr_we    = (r_state == tsup_pkg::S_CLEAR);
        // hold a word-final letter until the result register can take it
        w_fire      = (r_state == tsup_pkg::S_EXEC) && (!r_last || w_out_free);
    end

    // ---------------- letter update ----------------
    always_comb begin
        w_lane     = r_row[r_sym];
        w_lane_ptr = w_lane[NODE_W-1:0];
        w_lane_cnt = w_lane[LANE_W-1 -: CNT_W];
        w_cnt_inc  = (w_lane_cnt == tsup_pkg::CNT_MAX) ? w_lane_cnt
                                                        : w_lane_cnt + 1'b1;

        n_cur       = r_cur;
        n_cur_cnt   = r_cur_cnt;
        n_pos       = r_pos;
        n_found     = r_found;
        n_found_len = r_found_len;
        n_err       = r_err;
        n_next_free = r_next_free;
        w_we        = 1'b0;
        w_alloc     = 1'b0;
        w_wlane     = '0;

        if (r_pos >= POS_LIM) begin
            // word too long: drop the letter
            if (r_err == tsup_pkg::STAT_OK) begin
                n_err = tsup_pkg::STAT_LONG;
            end
        end else begin
            n_pos = r_pos + 1'b1;
            if (r_req == tsup_pkg::REQ_QUERY) begin
                if (!r_found) begin
                    if (r_cur_cnt == CNT_W'(1)) begin
                        n_found     = 1'b1;
                        n_found_len = r_pos;
                    end else begin
                        // a missing child reads as node zero, the root
                        n_cur     = w_lane_ptr;
                        n_cur_cnt = w_lane_cnt;
                    end
                end
            end else if (r_err != tsup_pkg::STAT_FULL) begin
                if (w_lane_ptr == '0) begin
                    if (r_next_free >= FREE_LIM) begin
                        if (r_err == tsup_pkg::STAT_OK) begin
                            n_err = tsup_pkg::STAT_FULL;
                        end
                    end else begin
                        w_alloc     = w_fire;
                        w_we        = w_fire;
                        n_cur       = NODE_W'(r_next_free);
                        n_cur_cnt   = CNT_W'(1);
                        n_next_free = r_next_free + 1'b1;
                        w_wlane     = {CNT_W'(1), NODE_W'(r_next_free)};
                    end
                end else begin
                    w_we      = w_fire;
                    n_cur     = w_lane_ptr;
                    n_cur_cnt = w_cnt_inc;
                    w_wlane   = {w_cnt_inc, w_lane_ptr};
                end
            end
        end

        if (r_req == tsup_pkg::REQ_QUERY) begin
            w_len = n_found ? n_found_len : n_pos;
        end else begin
            w_len = '0;
        end
        n_out_len = tsup_pkg::LEN_W'(w_len);
    end

    // ---------------- child row memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_clr_we) begin
            mem_child[r_clr] <= '0;
        end else if (w_we) begin
            mem_child[r_cur][r_sym] <= w_wlane;
        end
        if (w_accept) begin
            r_row <= mem_child[r_cur];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= tsup_pkg::t_req'(i_req.req_type);
            r_sym  <= w_sym_tab[i_req.letter];
            r_last <= i_req.last;
        end
        if (w_fire && r_last) begin
            r_out_len    <= n_out_len;
            r_out_status <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsup_pkg::S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_cur_cnt   <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_found_len <= '0;
            r_err       <= tsup_pkg::STAT_OK;
            r_next_free <= FREE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_fire) begin
                r_next_free <= n_next_free;
                if (r_last) begin
                    // word ends: back to the root
                    r_cur       <= '0;
                    r_cur_cnt   <= '0;
                    r_pos       <= '0;
                    r_found     <= 1'b0;
                    r_found_len <= '0;
                    r_err       <= tsup_pkg::STAT_OK;
                end else begin
                    r_cur       <= n_cur;
                    r_cur_cnt   <= n_cur_cnt;
                    r_pos       <= n_pos;
                    r_found     <= n_found;
                    r_found_len <= n_found_len;
                    r_err       <= n_err;
                end
            end
            if (w_fire && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.prefix_len = r_out_len;
    assign o_rsp.status     = r_out_status;

    // ---------------- assertions ----------------
    `TSUP_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, 1'b1, r_next_free <= FREE_LIM, "free node count beyond table")
    `TSUP_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_LIM, "letter position beyond maximum word length")
    `TSUP_ASSERT_NXT(a_last_result, i_clk, i_rst_n, w_fire && r_last, r_out_valid && r_pos == '0 && r_cur == '0, "word end did not give a result and clear the walk")
    `TSUP_ASSERT_NXT(a_alloc_step, i_clk, i_rst_n, w_alloc, r_next_free == $past(r_next_free) + 1'b1, "allocation did not advance the free node count")

endmodule
